FILE: hdl/abd3_pkg.sv
// ----------------------------------------------------------------------------
// abd3_pkg
// Types, constants and helpers shared by the 3x3 ARGB box downscaler.
// ----------------------------------------------------------------------------
package abd3_pkg;

  localparam int PIXEL_W   = 32;
  localparam int CHAN_W    = 8;
  localparam int SUM_W     = 12;
  localparam int NUM_CHAN  = 4;
  localparam int ENTRY_W   = NUM_CHAN * SUM_W;
  localparam int DIM_W     = 12;
  localparam int FACTOR    = 3;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 12'd480;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // floor(2^16 / 9) + 1, exact for all 12-bit sums
  localparam logic [12:0] RECIP_NINE = 13'd7282;

  typedef struct packed {
    logic [DIM_W-1:0] bcol;
    logic             keep;
    logic             first;
    logic             last;
    logic             eof;
  } pos_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_res;
    logic               eof;
  } res_t;

  function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [24:0] prod;
    prod = {13'd0, s} * {12'd0, RECIP_NINE};
    return prod[23:16];
  endfunction

endpackage

FILE: hdl/abd3_if.sv
// ----------------------------------------------------------------------------
// abd3 stream interfaces
// Valid/ready channels for input pixels and averaged output pixels.
// ----------------------------------------------------------------------------
interface abd3_in_if;
  logic                         valid;
  logic                         ready;
  logic [abd3_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface abd3_out_if;
  logic                         valid;
  logic                         ready;
  logic [abd3_pkg::PIXEL_W-1:0] pixel_res;
  logic                         end_of_frame;

  modport source (output valid, output pixel_res, output end_of_frame, input ready);
  modport sink   (input valid, input pixel_res, input end_of_frame, output ready);
endinterface

FILE: hdl/abd3_ctrl.sv
// ----------------------------------------------------------------------------
// abd3_ctrl
// Size registers and raster position counters; classifies each pixel.
// ----------------------------------------------------------------------------
module abd3_ctrl #(
  parameter int STORE_DEPTH = 1365
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [abd3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [abd3_pkg::DIM_W-1:0]       cfg_wdata,
  input  logic                             accept,
  output abd3_pkg::pos_t                   pos
);

  logic [abd3_pkg::DIM_W-1:0] width_r,  width_nxt;
  logic [abd3_pkg::DIM_W-1:0] height_r, height_nxt;
  logic [abd3_pkg::DIM_W-1:0] col_r,  col_nxt;
  logic [abd3_pkg::DIM_W-1:0] bcol_r, bcol_nxt;
  logic [1:0]                 cph_r,  cph_nxt;
  logic [abd3_pkg::DIM_W-1:0] row_r,  row_nxt;
  logic [abd3_pkg::DIM_W-1:0] brow_r, brow_nxt;
  logic [1:0]                 rph_r,  rph_nxt;

  logic [13:0] base_c, base_r;
  logic        col_ok, row_ok, col_endblk, row_endblk, store_ok;
  logic        col_wrap, row_wrap;

  always_comb begin
    base_c     = {1'b0, bcol_r, 1'b0} + {2'b0, bcol_r} + 14'd3;
    base_r     = {1'b0, brow_r, 1'b0} + {2'b0, brow_r} + 14'd3;
    col_ok     = base_c <= {2'b0, width_r};
    row_ok     = base_r <= {2'b0, height_r};
    col_endblk = (base_c + 14'd3) > {2'b0, width_r};
    row_endblk = (base_r + 14'd3) > {2'b0, height_r};
    store_ok   = {20'd0, bcol_r} < 32'(STORE_DEPTH);

    pos.bcol  = bcol_r;
    pos.keep  = col_ok && row_ok && store_ok;
    pos.first = (cph_r == 2'd0) && (rph_r == 2'd0);
    pos.last  = (cph_r == 2'd2) && (rph_r == 2'd2);
    pos.eof   = col_endblk && row_endblk;
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        abd3_pkg::CFG_IMAGE_WIDTH:  width_nxt  = cfg_wdata;
        abd3_pkg::CFG_IMAGE_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end

    col_wrap = ({1'b0, col_r} + 13'd1) >= {1'b0, width_r};
    row_wrap = ({1'b0, row_r} + 13'd1) >= {1'b0, height_r};

    col_nxt  = col_r;
    cph_nxt  = cph_r;
    bcol_nxt = bcol_r;
    row_nxt  = row_r;
    rph_nxt  = rph_r;
    brow_nxt = brow_r;
    if (accept) begin
      if (col_wrap) begin
        col_nxt  = '0;
        cph_nxt  = '0;
        bcol_nxt = '0;
        if (row_wrap) begin
          row_nxt  = '0;
          rph_nxt  = '0;
          brow_nxt = '0;
        end else begin
          row_nxt = row_r + 12'd1;
          if (rph_r == 2'd2) begin
            rph_nxt  = '0;
            brow_nxt = brow_r + 12'd1;
          end else begin
            rph_nxt = rph_r + 2'd1;
          end
        end
      end else begin
        col_nxt = col_r + 12'd1;
        if (cph_r == 2'd2) begin
          cph_nxt  = '0;
          bcol_nxt = bcol_r + 12'd1;
        end else begin
          cph_nxt = cph_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= abd3_pkg::WIDTH_RST;
      height_r <= abd3_pkg::HEIGHT_RST;
      col_r    <= '0;
      cph_r    <= '0;
      bcol_r   <= '0;
      row_r    <= '0;
      rph_r    <= '0;
      brow_r   <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      cph_r    <= cph_nxt;
      bcol_r   <= bcol_nxt;
      row_r    <= row_nxt;
      rph_r    <= rph_nxt;
      brow_r   <= brow_nxt;
    end
  end

endmodule

FILE: hdl/abd3_accum.sv
// ----------------------------------------------------------------------------
// abd3_accum
// Column accumulator store with read-modify-write, forwarding and divide.
// ----------------------------------------------------------------------------
module abd3_accum #(
  parameter int STORE_DEPTH = 1365
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [abd3_pkg::PIXEL_W-1:0]   in_pixel,
  input  abd3_pkg::pos_t                 pos,
  input  logic                           out_free,
  output logic                           in_ready,
  output logic                           res_valid,
  output abd3_pkg::res_t                 res
);

  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [abd3_pkg::ENTRY_W-1:0] mem [STORE_DEPTH];
  logic [abd3_pkg::ENTRY_W-1:0] rd_q_r;
  logic [abd3_pkg::ENTRY_W-1:0] fwd_q_r;
  logic                         fwd_hit_r;

  logic                         s1_valid_r, s1_valid_nxt;
  abd3_pkg::pos_t               s1_pos_r;
  logic [abd3_pkg::PIXEL_W-1:0] s1_pixel_r;
  logic [ADDR_W-1:0]            s1_addr_r;

  logic                         rd_en, wr_en, s1_go, s1_emit;
  logic [ADDR_W-1:0]            rd_addr;
  logic [abd3_pkg::ENTRY_W-1:0] old_sum, new_sum;

  always_comb begin
    s1_emit   = s1_pos_r.keep && s1_pos_r.last;
    res_valid = s1_valid_r && s1_emit;
    s1_go     = s1_valid_r && (!s1_emit || out_free);
    in_ready  = !s1_valid_r || s1_go;
    rd_en     = in_valid && in_ready;
    rd_addr   = pos.bcol[ADDR_W-1:0];
    wr_en     = s1_go && s1_pos_r.keep;
    old_sum   = fwd_hit_r ? fwd_q_r : rd_q_r;

    for (int i = 0; i < abd3_pkg::NUM_CHAN; i++) begin
      if (s1_pos_r.first) begin
        new_sum[i*abd3_pkg::SUM_W +: abd3_pkg::SUM_W] =
          {4'd0, s1_pixel_r[i*abd3_pkg::CHAN_W +: abd3_pkg::CHAN_W]};
      end else begin
        new_sum[i*abd3_pkg::SUM_W +: abd3_pkg::SUM_W] =
          old_sum[i*abd3_pkg::SUM_W +: abd3_pkg::SUM_W] +
          {4'd0, s1_pixel_r[i*abd3_pkg::CHAN_W +: abd3_pkg::CHAN_W]};
      end
      res.pixel_res[i*abd3_pkg::CHAN_W +: abd3_pkg::CHAN_W] =
        abd3_pkg::div9(new_sum[i*abd3_pkg::SUM_W +: abd3_pkg::SUM_W]);
    end
    res.eof = s1_pos_r.eof;

    s1_valid_nxt = s1_valid_r;
    if (rd_en) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr_r] <= new_sum;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // bypass a write landing on the entry read at the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_hit_r  <= wr_en && (s1_addr_r == rd_addr);
      fwd_q_r    <= new_sum;
      s1_pos_r   <= pos;
      s1_pixel_r <= in_pixel;
      s1_addr_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

endmodule

FILE: hdl/argb_box_downscale_by_three.sv
// ----------------------------------------------------------------------------
// argb_box_downscale_by_three
// Averages non-overlapping 3x3 blocks of a raster ARGB stream.
// Path: stage-1 register with the store read, then the output register.
// Throughput: 1 word per cycle unless the output stalls; one store read and
//   one write each cycle, same-entry hazards covered by a one-entry bypass.
// Reset: counters cleared, size 640x480; accumulator store is not cleared.
// ----------------------------------------------------------------------------
module argb_box_downscale_by_three #(
  parameter int MAX_WIDTH = 4095
) (
  input  logic                           clk,
  input  logic                           rst_n,
  abd3_in_if.sink                        in_chan,
  abd3_out_if.source                     out_chan,
  input  logic                           cfg_wr_en,
  input  logic [abd3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abd3_pkg::DIM_W-1:0]     cfg_wdata
);

  localparam int STORE_DEPTH = MAX_WIDTH / abd3_pkg::FACTOR;

  abd3_pkg::pos_t pos;
  abd3_pkg::res_t res;
  logic           accept, in_ready, res_valid, out_free;

  logic                         out_valid_r, out_valid_nxt;
  logic [abd3_pkg::PIXEL_W-1:0] out_pixel_r;
  logic                         out_eof_r;

  assign in_chan.ready         = in_ready;
  assign accept                = in_chan.valid && in_ready;
  assign out_free              = !out_valid_r || out_chan.ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.pixel_res    = out_pixel_r;
  assign out_chan.end_of_frame = out_eof_r;

  abd3_ctrl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .pos       (pos)
  );

  abd3_accum #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_pixel  (in_chan.pixel),
    .pos       (pos),
    .out_free  (out_free),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_pixel_r <= res.pixel_res;
      out_eof_r   <= res.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !out_free |=> res_valid)
    else $error("pending block result dropped");

  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (!res_valid || out_free))
    else $error("word accepted while result stage stalled");

  a_load_output: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && out_free |=> out_chan.valid)
    else $error("output register failed to load");
`endif

endmodule

FILE: tb/tb_argb_box_downscale_by_three.sv
// ----------------------------------------------------------------------------
// tb_argb_box_downscale_by_three
// Drives raster ARGB frames of assorted sizes into the 3x3 box downscaler.
// A cycle-free predictor keeps its own column/row counters and per-column
// block sums, and queues each expected averaged word. Every output word is
// compared against the queue in order. Both sides idle and stall at random,
// and the output side holds off once for a long stretch to fill the block.
// ----------------------------------------------------------------------------
module tb_argb_box_downscale_by_three;

  localparam int MAX_WIDTH       = 4095;
  localparam int STORE_DEPTH     = MAX_WIDTH / abd3_pkg::FACTOR;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 4;
  localparam int TOTAL_ITEMS     = 550;
  localparam int FILL_WIDTH      = 60;

  typedef logic [abd3_pkg::DIM_W-1:0]     dim_t;
  typedef logic [abd3_pkg::PIXEL_W-1:0]   pix_t;
  typedef logic [abd3_pkg::SUM_W-1:0]     sum_t;
  typedef logic [abd3_pkg::CHAN_W-1:0]    chan_t;
  typedef logic [abd3_pkg::ENTRY_W-1:0]   entry_t;
  typedef logic [abd3_pkg::CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  class box_avg_tracker_t;
    dim_t           img_w;
    dim_t           img_h;
    dim_t           col_cnt;
    dim_t           row_cnt;
    entry_t         sums [STORE_DEPTH];
    abd3_pkg::res_t expected_avgs[$];
    int unsigned    errors;

    function new();
      img_w   = abd3_pkg::WIDTH_RST;
      img_h   = abd3_pkg::HEIGHT_RST;
      col_cnt = '0;
      row_cnt = '0;
      errors  = 0;
    endfunction

    function void write_reg(input cfg_idx_t index, input dim_t value);
      if (index == abd3_pkg::CFG_IMAGE_WIDTH) begin
        img_w = value;
      end else if (index == abd3_pkg::CFG_IMAGE_HEIGHT) begin
        img_h = value;
      end
    endfunction

    function void step_counters(inout dim_t c, inout dim_t r);
      if (32'(c) + 1 >= 32'(img_w)) begin
        c = '0;
        if (32'(r) + 1 >= 32'(img_h)) begin
          r = '0;
        end else begin
          r = r + 1'b1;
        end
      end else begin
        c = c + 1'b1;
      end
    endfunction

    function bit at_frame_start();
      return (col_cnt == '0) && (row_cnt == '0);
    endfunction

    function int unsigned pixels_to_frame_end();
      dim_t        c;
      dim_t        r;
      int unsigned steps;
      c     = col_cnt;
      r     = row_cnt;
      steps = 0;
      do begin
        step_counters(c, r);
        steps++;
      end while (c != '0 || r != '0);
      return steps;
    endfunction

    function void note_pixel(input pix_t px);
      int unsigned    c;
      int unsigned    r;
      int unsigned    out_w;
      int unsigned    out_h;
      int unsigned    bc;
      int unsigned    br;
      sum_t           s [abd3_pkg::NUM_CHAN];
      entry_t         prev;
      abd3_pkg::res_t avg;
      c     = 32'(col_cnt);
      r     = 32'(row_cnt);
      out_w = 32'(img_w) / abd3_pkg::FACTOR;
      out_h = 32'(img_h) / abd3_pkg::FACTOR;
      bc    = c / abd3_pkg::FACTOR;
      br    = r / abd3_pkg::FACTOR;
      if (c < out_w * abd3_pkg::FACTOR && r < out_h * abd3_pkg::FACTOR &&
          bc < STORE_DEPTH) begin
        prev = sums[bc];
        for (int k = 0; k < abd3_pkg::NUM_CHAN; k++) begin
          if (c % abd3_pkg::FACTOR == 0 && r % abd3_pkg::FACTOR == 0) begin
            s[k] = sum_t'(px[abd3_pkg::CHAN_W*k +: abd3_pkg::CHAN_W]);
          end else begin
            s[k] = prev[abd3_pkg::SUM_W*k +: abd3_pkg::SUM_W] +
                   sum_t'(px[abd3_pkg::CHAN_W*k +: abd3_pkg::CHAN_W]);
          end
        end
        sums[bc] = {s[3], s[2], s[1], s[0]};
        if (c % abd3_pkg::FACTOR == abd3_pkg::FACTOR - 1 &&
            r % abd3_pkg::FACTOR == abd3_pkg::FACTOR - 1) begin
          for (int k = 0; k < abd3_pkg::NUM_CHAN; k++) begin
            avg.pixel_res[abd3_pkg::CHAN_W*k +: abd3_pkg::CHAN_W] =
              chan_t'(32'(s[k]) / (abd3_pkg::FACTOR * abd3_pkg::FACTOR));
          end
          avg.eof = (bc + 1 == out_w && br + 1 == out_h);
          expected_avgs.push_back(avg);
        end
      end
      step_counters(col_cnt, row_cnt);
    endfunction

    function void check_average(input pix_t pix, input logic eof);
      abd3_pkg::res_t want;
      if (expected_avgs.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected output word %h eof %0b", pix, eof);
        end
      end else begin
        want = expected_avgs.pop_front();
        if (want.pixel_res !== pix || want.eof !== eof) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected %h eof %0b, got %h eof %0b",
                     want.pixel_res, want.eof, pix, eof);
          end
        end
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  cfg_idx_t         cfg_index;
  dim_t             cfg_wdata;
  int unsigned      send_idle_pct;
  int unsigned      recv_stall_pct;
  int unsigned      phase_cnt;
  int unsigned      sent_cnt;
  bit               hold_off_pending;
  box_avg_tracker_t avg_sb;

  abd3_in_if  in_if();
  abd3_out_if out_if();

  argb_box_downscale_by_three u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic pix_t rand_pixel();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic choose_idling();
    idle_mode_t mode;
    mode = idle_mode_t'(phase_cnt % 4);
    phase_cnt++;
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_idle_pct  = 46;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 46;
      end
      default: begin
        send_idle_pct  = 37;
        recv_stall_pct = 37;
      end
    endcase
  endtask

  task automatic write_reg(input cfg_idx_t index, input dim_t value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    avg_sb.write_reg(index, value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_size(input dim_t w, input dim_t h);
    write_reg(abd3_pkg::CFG_IMAGE_WIDTH, w);
    write_reg(abd3_pkg::CFG_IMAGE_HEIGHT, h);
  endtask

  task automatic send_pixel(input pix_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.pixel <= px;
    do @(posedge clk); while (!in_if.ready);
    avg_sb.note_pixel(px);
    sent_cnt++;
    @(negedge clk);
  endtask

  // drop valid, wait out every expected word, then let in-flight words clear
  task automatic end_chunk();
    in_if.valid <= 1'b0;
    while (avg_sb.expected_avgs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      avg_sb.check_average(out_if.pixel_res, out_if.end_of_frame);
    end
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    dim_t        w;
    dim_t        h;
    int unsigned n;
    avg_sb           = new();
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.pixel      = '0;
    cfg_wr_en        = 1'b0;
    cfg_index        = abd3_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata        = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    phase_cnt        = 0;
    sent_cnt         = 0;
    hold_off_pending = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full-scale and truncating single-block frames
    set_size(12'd3, 12'd3);
    repeat (9) send_pixel('1);
    for (int i = 0; i < 9; i++) begin
      send_pixel(i == 4 ? 32'hFF08_0910 : 32'h0000_0000);
    end
    end_chunk();

    // tiny images: no output, counters still advance
    write_reg(abd3_pkg::CFG_IMAGE_WIDTH, 12'd2);
    repeat (4) send_pixel($urandom);
    end_chunk();
    set_size(12'd0, 12'd0);
    repeat (3) send_pixel($urandom);
    end_chunk();

    // hold off the output mid block row to back up the input
    choose_idling();
    set_size(dim_t'(FILL_WIDTH), 12'd3);
    for (int i = 0; i < FILL_WIDTH * 3; i++) begin
      if (i == 2 * FILL_WIDTH + 10) begin
        hold_off_pending = 1'b1;
      end
      send_pixel(rand_pixel());
    end
    end_chunk();

    // tallest size, then shrink below the row counter
    choose_idling();
    set_size(12'd3, 12'd4095);
    repeat (27) send_pixel(rand_pixel());
    end_chunk();
    set_size(12'd6, 12'd6);
    repeat (42) send_pixel(rand_pixel());
    end_chunk();

    // resize only between frames so every block starts before it is summed
    while (sent_cnt < TOTAL_ITEMS) begin
      choose_idling();
      if (avg_sb.at_frame_start()) begin
        w = dim_t'($urandom_range(3, 12));
        h = dim_t'($urandom_range(3, 12));
        if ($urandom_range(9) == 0) begin
          if ($urandom_range(1) == 0) begin
            w = dim_t'($urandom_range(0, 2));
          end else begin
            h = dim_t'($urandom_range(0, 2));
          end
        end
        if ($urandom_range(3) != 0) begin
          write_reg(abd3_pkg::CFG_IMAGE_WIDTH, w);
        end
        if ($urandom_range(3) != 0) begin
          write_reg(abd3_pkg::CFG_IMAGE_HEIGHT, h);
        end
      end
      n = avg_sb.pixels_to_frame_end();
      if (n > 1 && $urandom_range(3) == 0) begin
        n -= $urandom_range(1, n - 1);
      end
      repeat (n) send_pixel(rand_pixel());
      end_chunk();
    end

    repeat (8) @(posedge clk);
    if (avg_sb.errors == 0 && avg_sb.expected_avgs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
